>>> rtl/ezvr_pkg.sv
// ----------------------------------------------------------------------------
// ezvr_pkg
// Shared types, register indexes and the arctangent table for the Euler
// rotation core.
// ----------------------------------------------------------------------------
package ezvr_pkg;

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
   } rsp_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      CRD_IDLE,
      CRD_RUN,
      CRD_FINISH
   } crd_state_type;

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   // vector component width inside the rotation chain
   localparam int COMP_W = 33;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/ezvr_cordic.sv
// ----------------------------------------------------------------------------
// ezvr_cordic
// Angle registers and an iterative CORDIC that refreshes the sine and cosine
// of each axis whenever its angle is written, one iteration per cycle.
// ----------------------------------------------------------------------------
module ezvr_cordic #(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_data,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_x,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_x,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_y,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_y,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_z,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_z,
   output logic                          busy
);

   localparam int TW    = TRIG_FRAC_BITS + 2;
   localparam int SHIFT = 30 - TRIG_FRAC_BITS;
   localparam logic signed [33:0] ONE = 34'sd1 <<< TRIG_FRAC_BITS;

   logic [15:0] ang_x_ff, ang_y_ff, ang_z_ff;
   logic [2:0]  dirty_ff, dirty_in;
   ezvr_pkg::crd_state_type state_ff, state_in;
   ezvr_pkg::axis_type axis_ff, axis_in;
   logic                flip_ff, flip_in;
   logic [4:0]          iter_ff, iter_in;
   logic signed [33:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [TW-1:0] sx_ff, cxo_ff, sy_ff, cyo_ff, sz_ff, czo_ff;

   logic [15:0]         ang_sel;
   logic signed [16:0]  ang_red;
   logic                flip_sel;
   logic signed [33:0]  x_rnd, y_rnd, x_clp, y_clp;
   logic signed [TW-1:0] cos_fin, sin_fin;
   logic [2:0]          dirty_set;

   // angle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_x_ff <= '0;
         ang_y_ff <= '0;
         ang_z_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ezvr_pkg::AXIS_X: ang_x_ff <= csr_data;
            ezvr_pkg::AXIS_Y: ang_y_ff <= csr_data;
            ezvr_pkg::AXIS_Z: ang_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      dirty_set = '0;
      if (csr_valid) begin
         case (csr_index)
            ezvr_pkg::AXIS_X: dirty_set[0] = 1'b1;
            ezvr_pkg::AXIS_Y: dirty_set[1] = 1'b1;
            ezvr_pkg::AXIS_Z: dirty_set[2] = 1'b1;
            default: ;
         endcase
      end
   end

   // pick the lowest pending axis and fold its angle into [-90, +90] degrees
   always_comb begin
      if (dirty_ff[0]) begin
         axis_in = ezvr_pkg::AXIS_X;
         ang_sel = ang_x_ff;
      end else if (dirty_ff[1]) begin
         axis_in = ezvr_pkg::AXIS_Y;
         ang_sel = ang_y_ff;
      end else begin
         axis_in = ezvr_pkg::AXIS_Z;
         ang_sel = ang_z_ff;
      end
      ang_red  = 17'(signed'(ang_sel));
      flip_sel = 1'b0;
      if (ang_red > 17'sd16384) begin
         ang_red  = ang_red - 17'sd32768;
         flip_sel = 1'b1;
      end else if (ang_red < -17'sd16384) begin
         ang_red  = ang_red + 17'sd32768;
         flip_sel = 1'b1;
      end
   end

   generate
      if (SHIFT > 0) begin : g_round
         localparam logic signed [33:0] HALF = 34'sd1 <<< (SHIFT - 1);
         assign x_rnd = (cx_ff + HALF) >>> SHIFT;
         assign y_rnd = (cy_ff + HALF) >>> SHIFT;
      end else begin : g_noround
         assign x_rnd = cx_ff;
         assign y_rnd = cy_ff;
      end
   endgenerate

   always_comb begin
      x_clp = (x_rnd > ONE) ? ONE : ((x_rnd < -ONE) ? -ONE : x_rnd);
      y_clp = (y_rnd > ONE) ? ONE : ((y_rnd < -ONE) ? -ONE : y_rnd);
      cos_fin = flip_ff ? -x_clp[TW-1:0] : x_clp[TW-1:0];
      sin_fin = flip_ff ? -y_clp[TW-1:0] : y_clp[TW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      dirty_in = dirty_ff | dirty_set;
      flip_in  = flip_ff;
      iter_in  = iter_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      case (state_ff)
         ezvr_pkg::CRD_IDLE: begin
            if (dirty_ff != 3'b000) begin
               dirty_in = (dirty_ff & ~(3'b001 << axis_in)) | dirty_set;
               flip_in  = flip_sel;
               iter_in  = '0;
               cx_in    = ezvr_pkg::CORDIC_GAIN;
               cy_in    = '0;
               cz_in    = 34'(ang_red) <<< 16;
               state_in = ezvr_pkg::CRD_RUN;
            end
         end
         ezvr_pkg::CRD_RUN: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - (cy_ff >>> iter_ff);
               cy_in = cy_ff + (cx_ff >>> iter_ff);
               cz_in = cz_ff - 34'(ezvr_pkg::atan_turn(iter_ff));
            end else begin
               cx_in = cx_ff + (cy_ff >>> iter_ff);
               cy_in = cy_ff - (cx_ff >>> iter_ff);
               cz_in = cz_ff + 34'(ezvr_pkg::atan_turn(iter_ff));
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(ezvr_pkg::CORDIC_STEPS - 1)) begin
               state_in = ezvr_pkg::CRD_FINISH;
            end
         end
         ezvr_pkg::CRD_FINISH: begin
            state_in = ezvr_pkg::CRD_IDLE;
         end
         default: begin
            state_in = ezvr_pkg::CRD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ezvr_pkg::CRD_IDLE;
         dirty_ff <= 3'b111;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ezvr_pkg::CRD_IDLE) begin
         axis_ff <= axis_in;
      end
      flip_ff <= flip_in;
      iter_ff <= iter_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      if (state_ff == ezvr_pkg::CRD_FINISH) begin
         case (axis_ff)
            ezvr_pkg::AXIS_X: begin
               sx_ff  <= sin_fin;
               cxo_ff <= cos_fin;
            end
            ezvr_pkg::AXIS_Y: begin
               sy_ff  <= sin_fin;
               cyo_ff <= cos_fin;
            end
            default: begin
               sz_ff  <= sin_fin;
               czo_ff <= cos_fin;
            end
         endcase
      end
   end

   assign sin_x = sx_ff;
   assign cos_x = cxo_ff;
   assign sin_y = sy_ff;
   assign cos_y = cyo_ff;
   assign sin_z = sz_ff;
   assign cos_z = czo_ff;
   assign busy  = (dirty_ff != 3'b000) || (state_ff != ezvr_pkg::CRD_IDLE);

endmodule

>>> rtl/ezvr_rot_cell.sv
// ----------------------------------------------------------------------------
// ezvr_rot_cell
// One plane rotation: p = u*c - v*s, q = u*s + v*c, w passed along.
// Products in the first stage, sum, rounding and clamp in the second.
// ----------------------------------------------------------------------------
module ezvr_rot_cell #(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [32:0]               in_u,
   input  logic signed [32:0]               in_v,
   input  logic signed [32:0]               in_w,
   input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
   input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
   output logic                             out_valid,
   output logic signed [32:0]               out_p,
   output logic signed [32:0]               out_q,
   output logic signed [32:0]               out_w
);

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = ezvr_pkg::COMP_W + TW;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] LIM  = SW'(64'sd4294967295);

   logic                 va_ff, vb_ff;
   logic signed [PW-1:0] uc_ff, vs_ff, us_ff, vc_ff;
   logic signed [32:0]   wa_ff, p_ff, q_ff, wb_ff;
   logic signed [SW-1:0] sum_p, sum_q, rnd_p, rnd_q;
   logic signed [32:0]   p_in, q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_comb begin
      sum_p = SW'(uc_ff) - SW'(vs_ff) + HALF;
      sum_q = SW'(us_ff) + SW'(vc_ff) + HALF;
      rnd_p = sum_p >>> TRIG_FRAC_BITS;
      rnd_q = sum_q >>> TRIG_FRAC_BITS;
      if (rnd_p > LIM) p_in = LIM[32:0];
      else if (rnd_p < -LIM) p_in = -LIM[32:0];
      else p_in = rnd_p[32:0];
      if (rnd_q > LIM) q_in = LIM[32:0];
      else if (rnd_q < -LIM) q_in = -LIM[32:0];
      else q_in = rnd_q[32:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         uc_ff <= PW'(in_u) * PW'(cos_val);
         vs_ff <= PW'(in_v) * PW'(sin_val);
         us_ff <= PW'(in_u) * PW'(sin_val);
         vc_ff <= PW'(in_v) * PW'(cos_val);
         wa_ff <= in_w;
         p_ff  <= p_in;
         q_ff  <= q_in;
         wb_ff <= wa_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_p     = p_ff;
   assign out_q     = q_ff;
   assign out_w     = wb_ff;

endmodule

>>> rtl/euler_zxy_vector_rotation_core.sv
// ----------------------------------------------------------------------------
// euler_zxy_vector_rotation_core
// Rotates Q16.16 vectors about Z, then X, then Y by three programmed angles.
// ----------------------------------------------------------------------------
// A new vector is taken every cycle unless the output is held or a refresh is
// pending; it passes through three rotation cells of two stages each plus a
// saturating output register, all stalling together while the output is held.
// After reset and after each angle write the CORDIC refreshes sine and cosine
// of each written angle (all three after reset), during which req_ready stays low.
module euler_zxy_vector_rotation_core #(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ezvr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ezvr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int TW = TRIG_FRAC_BITS + 2;

   logic signed [TW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
   logic                 trig_busy, en;
   logic                 vz, vx, vy;
   logic signed [32:0]   pz, qz, wz, px, qx, wx, py, qy, wy;
   logic                 rsp_valid_ff;
   ezvr_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -33'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && !trig_busy;

   ezvr_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .sin_x(sin_x), .cos_x(cos_x), .sin_y(sin_y), .cos_y(cos_y),
      .sin_z(sin_z), .cos_z(cos_z), .busy(trig_busy)
   );

   // about z: (x, y) -> p = x1, q = y1, w = z
   ezvr_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_z (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid && req_ready),
      .in_u(33'(req_data.vec_x)), .in_v(33'(req_data.vec_y)),
      .in_w(33'(req_data.vec_z)), .sin_val(sin_z), .cos_val(cos_z),
      .out_valid(vz), .out_p(pz), .out_q(qz), .out_w(wz)
   );

   // about x: (y1, z) -> p = y2, q = z1, w = x1
   ezvr_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_x (
      .clock(clock), .reset(reset), .en(en), .in_valid(vz),
      .in_u(qz), .in_v(wz), .in_w(pz), .sin_val(sin_x), .cos_val(cos_x),
      .out_valid(vx), .out_p(px), .out_q(qx), .out_w(wx)
   );

   // about y: (z1, x1) -> p = z2, q = x2, w = y2
   ezvr_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_y (
      .clock(clock), .reset(reset), .en(en), .in_valid(vx),
      .in_u(qx), .in_v(wx), .in_w(px), .sin_val(sin_y), .cos_val(cos_y),
      .out_valid(vy), .out_p(py), .out_q(qy), .out_w(wy)
   );

   always_comb begin
      rsp_data_in.rot_x = sat32(qy);
      rsp_data_in.rot_y = sat32(wy);
      rsp_data_in.rot_z = sat32(py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vy;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      trig_busy |-> !req_ready)
      else $error("transaction accepted while trig refresh pending");

   a_write_starts_refresh: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index <= ezvr_pkg::AXIS_Z)) |=> trig_busy)
      else $error("angle write did not start trig refresh");

   a_reset_refresh: assert property (@(posedge clock)
      reset |=> trig_busy)
      else $error("no trig refresh after reset");

endmodule

>>> sim/euler_zxy_vector_rotation_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_zxy_vector_rotation_core_test
// Drives Q16.16 vectors through the Z-X-Y rotation core under several angle
// settings, with random stalls on both sides, and checks every rotated
// vector against a bit-exact CORDIC and fixed-point rotation predictor.
// ----------------------------------------------------------------------------
module euler_zxy_vector_rotation_core_test;

   localparam int FRAC = 16;
   localparam longint ILIM = 64'sd4294967295;
   localparam int WD_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   ezvr_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   ezvr_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   euler_zxy_vector_rotation_core #(.TRIG_FRAC_BITS(FRAC)) u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] ang_x = '0, ang_y = '0, ang_z = '0;
   ezvr_pkg::req_type vec_queue[$];
   ezvr_pkg::rsp_type rotated_queue[$];
   int  errors = 0;
   bit  calm = 1'b0;   // no idling on either side
   bit  hold_off = 1'b0;
   int  idle_cycles = 0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
      int a;
      bit flip;
      longint x, y, z, dx, dy, one, half;
      a = ang;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (a >= 32768) a -= 65536;
      if (a > 16384) begin
         a -= 32768; flip = 1'b1;
      end else if (a < -16384) begin
         a += 32768; flip = 1'b1;
      end
      z = longint'(a) * 65536;
      for (int i = 0; i < ezvr_pkg::CORDIC_STEPS; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ezvr_pkg::atan_turn(i[4:0]));
         end else begin
            x += dx; y -= dy; z += longint'(ezvr_pkg::atan_turn(i[4:0]));
         end
      end
      half = 64'sd1 <<< (29 - FRAC);
      x = floor_shr(x + half, 30 - FRAC);
      y = floor_shr(y + half, 30 - FRAC);
      one = 64'sd1 <<< FRAC;
      x = clip(x, -one, one);
      y = clip(y, -one, one);
      if (flip) begin
         x = -x; y = -y;
      end
      sn = y;
      cs = x;
   endtask

   function automatic longint mac(longint a, longint b, longint c, longint d);
      return floor_shr(a * b + c * d + (64'sd1 <<< (FRAC - 1)), FRAC);
   endfunction

   task automatic rotate_vector(input ezvr_pkg::req_type v, output ezvr_pkg::rsp_type r);
      longint sx, cx, sy, cy, sz, cz, x, y, z, x1, y1, y2, z1, x2, z2;
      sin_cos(ang_x, sx, cx);
      sin_cos(ang_y, sy, cy);
      sin_cos(ang_z, sz, cz);
      x = v.vec_x; y = v.vec_y; z = v.vec_z;
      x1 = clip(mac(x, cz, -y, sz), -ILIM, ILIM);
      y1 = clip(mac(x, sz, y, cz), -ILIM, ILIM);
      y2 = clip(mac(y1, cx, -z, sx), -ILIM, ILIM);
      z1 = clip(mac(y1, sx, z, cx), -ILIM, ILIM);
      x2 = mac(z1, sy, x1, cy);
      z2 = mac(z1, cy, -x1, sy);
      r.rot_x = 32'(clip(x2, -64'sd2147483648, 64'sd2147483647));
      r.rot_y = 32'(clip(y2, -64'sd2147483648, 64'sd2147483647));
      r.rot_z = 32'(clip(z2, -64'sd2147483648, 64'sd2147483647));
   endtask

   function automatic bit roll_idle();
      return !calm && ($urandom_range(99) < 28);
   endfunction

   // driver
   always @(posedge clock) begin
      ezvr_pkg::rsp_type r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rotate_vector(req_data, r);
            rotated_queue.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (vec_queue.size() > 0 && !hold_off && !roll_idle()) begin
               req_valid <= 1'b1;
               req_data  <= vec_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !roll_idle();
      end
   end

   // monitor
   always @(posedge clock) begin
      ezvr_pkg::rsp_type e;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (rotated_queue.size() == 0) begin
               $error("unexpected transaction rot_x=%0d", rsp_data.rot_x);
               errors++;
            end else begin
               e = rotated_queue.pop_front();
               if (rsp_data.rot_x !== e.rot_x) begin
                  $error("rot_x expected %0d actual %0d", e.rot_x, rsp_data.rot_x);
                  errors++;
               end
               if (rsp_data.rot_y !== e.rot_y) begin
                  $error("rot_y expected %0d actual %0d", e.rot_y, rsp_data.rot_y);
                  errors++;
               end
               if (rsp_data.rot_z !== e.rot_z) begin
                  $error("rot_z expected %0d actual %0d", e.rot_z, rsp_data.rot_z);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WD_LIMIT) begin
         $display("euler_zxy_vector_rotation_core_test: errors");
         $finish;
      end
   end

   task automatic drain();
      while (vec_queue.size() > 0 || req_valid || rotated_queue.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // leaves csr_valid high, the caller drops it after the last write
   task automatic write_angle(input ezvr_pkg::axis_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ezvr_pkg::AXIS_X: ang_x = val;
         ezvr_pkg::AXIS_Y: ang_y = val;
         default: ang_z = val;
      endcase
   endtask

   task automatic set_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
      drain();
      write_angle(ezvr_pkg::AXIS_X, ax);
      write_angle(ezvr_pkg::AXIS_Y, ay);
      write_angle(ezvr_pkg::AXIS_Z, az);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(65536 * 20)) - 65536 * 10);
         default: return $urandom();
      endcase
   endfunction

   task automatic push_vec(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
      ezvr_pkg::req_type v;
      v.vec_x = x; v.vec_y = y; v.vec_z = z;
      vec_queue.push_back(v);
   endtask

   task automatic push_random(input int n);
      repeat (n) push_vec(rand_comp(), rand_comp(), rand_comp());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: zero angles, extremes of the components
      push_vec(0, 0, 0);
      push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_vec(32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
      drain();
      // quarter and half turns plus reduction boundaries
      set_angles(16'd16384, 16'd32768, 16'd49152);
      push_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      push_vec(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
      push_vec(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      set_angles(16'd16385, 16'd16383, 16'd49151);
      push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      push_vec(32'h0001_0000, 32'hffff_ffff, 32'h0000_8000);
      set_angles(16'hffff, 16'hffff, 16'hffff);
      push_vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      push_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      set_angles(16'd8192, 16'd24576, 16'd40960);
      push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_vec(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff);
      // random angle sets
      for (int p = 0; p < 9; p++) begin
         set_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
         calm = (p == 4);
         push_random(100);
         if (p == 2) begin
            // pause the sender until every expected transaction is back
            while (vec_queue.size() > 50) @(posedge clock);
            hold_off = 1'b1;
            while (rotated_queue.size() > 0 || req_valid) @(posedge clock);
            hold_off = 1'b0;
         end
      end
      push_random(50);
      calm = 1'b0;
      drain();
      if (errors == 0)
         $display("euler_zxy_vector_rotation_core_test: clean");
      else
         $display("euler_zxy_vector_rotation_core_test: errors");
      $finish;
   end

endmodule

>>> files.f
rtl/ezvr_pkg.sv
rtl/ezvr_cordic.sv
rtl/ezvr_rot_cell.sv
rtl/euler_zxy_vector_rotation_core.sv
sim/euler_zxy_vector_rotation_core_test.sv
